// File: hw/rtl/bgc_pkg.sv
`timescale 1ns / 1ps

package bgc_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int VID_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = VID_W + 1;
  localparam int MAX_EDGES    = 256;
  localparam int SLOTS        = 2 * MAX_EDGES;
  localparam int SLOT_AW      = $clog2(SLOTS);
  localparam int SLOT_W       = SLOT_AW + 1;

  localparam logic [SLOT_W-1:0] NO_SLOT    = SLOT_W'(SLOTS);
  localparam logic [CNT_W-1:0]  VCOUNT_MAX = CNT_W'(MAX_VERTICES);

  // Colour codes; uncoloured vertices are marked by a clear valid bit.
  localparam logic [1:0] COLOR_A = 2'd1;
  localparam logic [1:0] COLOR_B = 2'd2;

  typedef struct packed {
    logic [VID_W-1:0] end_a;
    logic [VID_W-1:0] end_b;
    logic             edge_valid;
    logic             last_edge;
  } bgc_in_t;

  typedef struct packed {
    logic is_bipartite;
    logic edge_overflow;
    logic bad_vertex;
  } bgc_out_t;

  typedef struct packed {
    logic             en;
    logic [VID_W-1:0] addr;
    logic [1:0]       color;
  } bgc_color_wr_t;

endpackage

// File: hw/rtl/bgc_color_store.sv
`timescale 1ns / 1ps

module bgc_color_store import bgc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     clear,
  input  bgc_color_wr_t            wr,
  input  logic [VID_W-1:0]         rd_addr,
  output logic [1:0]               rd_color,
  input  logic [VID_W-1:0]         chk_addr,
  output logic                     chk_colored
);

  logic [1:0]              color_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] colored_r;

  // A vertex whose valid bit is clear counts as uncoloured, so clearing is instant.
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      colored_r <= '0;
    end else if (wr.en) begin
      colored_r[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      color_mem[wr.addr] <= wr.color;
    end
    rd_color <= color_mem[rd_addr];
  end

  assign chk_colored = colored_r[chk_addr];

endmodule

// File: hw/rtl/bipartite_graph_check.sv
`timescale 1ns / 1ps

// Channel   Direction  Ports                          Word
// input     in         start, busy, in_data           one edge (or empty item)
// result    out        out_valid, out_data            one verdict per last item
// config    in         cfg_valid, cfg_ready, cfg_data vertex count
//
// An item that stores no edge is taken in ST_IDLE; a stored edge is linked in ST_LDRD,
// ST_LDWR1 and ST_LDWR2. The walk after a last item scans vertices in ST_SCAN, pops each
// through ST_POP, ST_POP2 and ST_HEAD and visits each adjacency slot in ST_NB and ST_CMP,
// bounded by the single read port of the adjacency store, then ends in ST_DONE.
// Reset is synchronous and active low; the graph store needs no clearing pass.
// out_valid is a one-cycle strobe; the receiver cannot stall it.

module bipartite_graph_check import bgc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  bgc_in_t          in_data,
  output logic             out_valid,
  output bgc_out_t         out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_LDRD  = 11'b000_0000_0010,
    ST_LDWR1 = 11'b000_0000_0100,
    ST_LDWR2 = 11'b000_0000_1000,
    ST_SCAN  = 11'b000_0001_0000,
    ST_POP   = 11'b000_0010_0000,
    ST_POP2  = 11'b000_0100_0000,
    ST_HEAD  = 11'b000_1000_0000,
    ST_NB    = 11'b001_0000_0000,
    ST_CMP   = 11'b010_0000_0000,
    ST_DONE  = 11'b100_0000_0000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   vcount_r;
  logic [CNT_W-1:0]   n_eff;
  logic [VID_W-1:0]   a_r, b_r;
  logic               last_r;
  logic [SLOT_W-1:0]  slot_r;
  logic               ovf_r, bad_r, ok_r;
  logic [CNT_W-1:0]   i_r, rd_r, wr_r;
  logic [1:0]         ucol_r;
  logic [VID_W-1:0]   v_r;
  logic [SLOT_W-1:0]  nxt_r;
  logic               out_valid_r;
  bgc_out_t           out_data_r;
  logic               accept, edge_bad;

  logic [SLOT_W-1:0]       head_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] head_v_r;
  logic [VID_W-1:0]        nbr_mem  [SLOTS];
  logic [SLOT_W-1:0]       next_mem [SLOTS];
  logic [VID_W-1:0]        queue_mem [MAX_VERTICES];

  logic [SLOT_W-1:0]  hq0, hq1;
  logic               hq0_v, hq1_v;
  logic [VID_W-1:0]   h0_addr;
  logic [VID_W-1:0]   nbr_q;
  logic [SLOT_W-1:0]  next_q;
  logic [SLOT_AW-1:0] adj_rd_addr;
  logic [VID_W-1:0]   q_rdata;

  logic               head_we;
  logic [VID_W-1:0]   head_waddr;
  logic [SLOT_W-1:0]  head_wdata;
  logic               adj_we;
  logic [SLOT_AW-1:0] adj_waddr;
  logic [VID_W-1:0]   adj_wnbr;
  logic [SLOT_W-1:0]  adj_wnext;
  logic               q_we;
  logic [VID_W-1:0]   q_waddr, q_wdata;

  bgc_color_wr_t      cwr;
  logic [VID_W-1:0]   c_rd_addr, c_chk_addr;
  logic [1:0]         c_rd_color;
  logic               c_colored;
  logic               clear_graph;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign n_eff     = (vcount_r > VCOUNT_MAX) ? VCOUNT_MAX : vcount_r;
  assign edge_bad  = ({1'b0, in_data.end_a} >= n_eff) || ({1'b0, in_data.end_b} >= n_eff);
  assign clear_graph = (state_r == ST_DONE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.edge_valid && !edge_bad && (slot_r <= SLOT_W'(SLOTS - 2))) begin
            state_nxt = ST_LDRD;
          end else if (in_data.last_edge) begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_LDRD:  state_nxt = ST_LDWR1;
      ST_LDWR1: state_nxt = ST_LDWR2;
      ST_LDWR2: state_nxt = last_r ? ST_SCAN : ST_IDLE;
      ST_SCAN: begin
        if (i_r >= n_eff) begin
          state_nxt = ST_DONE;
        end else if (!c_colored) begin
          state_nxt = ST_POP;
        end
      end
      ST_POP:  state_nxt = (rd_r == wr_r) ? ST_SCAN : ST_POP2;
      ST_POP2: state_nxt = ST_HEAD;
      ST_HEAD: state_nxt = hq0_v ? ST_NB : ST_POP;
      ST_NB:   state_nxt = ST_CMP;
      ST_CMP: begin
        if (c_colored && (c_rd_color == ucol_r)) begin
          state_nxt = ST_DONE;
        end else if (nxt_r >= NO_SLOT) begin
          state_nxt = ST_POP;
        end else begin
          state_nxt = ST_NB;
        end
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Memory port steering.
  always_comb begin
    h0_addr     = (state_r == ST_LDRD) ? a_r : q_rdata;
    adj_rd_addr = (state_r == ST_HEAD) ? hq0[SLOT_AW-1:0] : nxt_r[SLOT_AW-1:0];
    c_rd_addr   = (state_r == ST_POP2) ? q_rdata : nbr_q;
    c_chk_addr  = (state_r == ST_SCAN) ? i_r[VID_W-1:0] : v_r;

    head_we    = (state_r == ST_LDWR1) || (state_r == ST_LDWR2);
    head_waddr = (state_r == ST_LDWR1) ? a_r : b_r;
    head_wdata = (state_r == ST_LDWR1) ? slot_r : slot_r + SLOT_W'(1);

    adj_we    = head_we;
    adj_waddr = head_wdata[SLOT_AW-1:0];
    adj_wnbr  = (state_r == ST_LDWR1) ? b_r : a_r;
    if (state_r == ST_LDWR1) begin
      adj_wnext = hq0_v ? hq0 : NO_SLOT;
    end else if (a_r == b_r) begin
      // A self-loop's second slot follows the first one just linked.
      adj_wnext = slot_r;
    end else begin
      adj_wnext = hq1_v ? hq1 : NO_SLOT;
    end

    cwr.en    = 1'b0;
    cwr.addr  = v_r;
    cwr.color = ucol_r ^ 2'b11;
    q_we      = 1'b0;
    q_waddr   = wr_r[VID_W-1:0];
    q_wdata   = v_r;
    if ((state_r == ST_SCAN) && (i_r < n_eff) && !c_colored) begin
      cwr.en    = 1'b1;
      cwr.addr  = i_r[VID_W-1:0];
      cwr.color = COLOR_A;
      q_we      = 1'b1;
      q_waddr   = '0;
      q_wdata   = i_r[VID_W-1:0];
    end else if ((state_r == ST_CMP) && !c_colored) begin
      cwr.en = 1'b1;
      q_we   = (wr_r < CNT_W'(MAX_VERTICES));
    end
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    hq0   <= head_mem[h0_addr];
    hq0_v <= head_v_r[h0_addr];
    hq1   <= head_mem[b_r];
    hq1_v <= head_v_r[b_r];
  end

  always_ff @(posedge clk) begin
    if (adj_we) begin
      nbr_mem[adj_waddr]  <= adj_wnbr;
      next_mem[adj_waddr] <= adj_wnext;
    end
    nbr_q  <= nbr_mem[adj_rd_addr];
    next_q <= next_mem[adj_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      queue_mem[q_waddr] <= q_wdata;
    end
    q_rdata <= queue_mem[rd_r[VID_W-1:0]];
  end

  bgc_color_store u_color (
    .clk         (clk),
    .rst_n       (rst_n),
    .clear       (clear_graph),
    .wr          (cwr),
    .rd_addr     (c_rd_addr),
    .rd_color    (c_rd_color),
    .chk_addr    (c_chk_addr),
    .chk_colored (c_colored)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vcount_r    <= VCOUNT_MAX;
      head_v_r    <= '0;
      slot_r      <= '0;
      ovf_r       <= 1'b0;
      bad_r       <= 1'b0;
      ok_r        <= 1'b1;
      i_r         <= '0;
      rd_r        <= '0;
      wr_r        <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        vcount_r <= cfg_data;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            a_r    <= in_data.end_a;
            b_r    <= in_data.end_b;
            last_r <= in_data.last_edge;
            i_r    <= '0;
            ok_r   <= 1'b1;
            if (in_data.edge_valid) begin
              if (edge_bad) begin
                bad_r <= 1'b1;
              end else if (slot_r > SLOT_W'(SLOTS - 2)) begin
                ovf_r <= 1'b1;
              end
            end
          end
        end
        ST_LDWR1: head_v_r[a_r] <= 1'b1;
        ST_LDWR2: begin
          head_v_r[b_r] <= 1'b1;
          slot_r        <= slot_r + SLOT_W'(2);
        end
        ST_SCAN: begin
          if ((i_r < n_eff) && !c_colored) begin
            rd_r <= '0;
            wr_r <= CNT_W'(1);
          end else if (i_r < n_eff) begin
            i_r <= i_r + CNT_W'(1);
          end
        end
        ST_POP: begin
          if (rd_r != wr_r) begin
            rd_r <= rd_r + CNT_W'(1);
          end
        end
        ST_HEAD: ucol_r <= c_rd_color;
        ST_NB: begin
          v_r   <= nbr_q;
          nxt_r <= next_q;
        end
        ST_CMP: begin
          if (!c_colored) begin
            if (wr_r < CNT_W'(MAX_VERTICES)) begin
              wr_r <= wr_r + CNT_W'(1);
            end
          end else if (c_rd_color == ucol_r) begin
            ok_r <= 1'b0;
          end
        end
        ST_DONE: begin
          out_valid_r              <= 1'b1;
          out_data_r.is_bipartite  <= ok_r;
          out_data_r.edge_overflow <= ovf_r;
          out_data_r.bad_vertex    <= bad_r;
          head_v_r                 <= '0;
          slot_r                   <= '0;
          ovf_r                    <= 1'b0;
          bad_r                    <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // The verdict is a single-cycle strobe.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("verdict strobe lasted more than one cycle");

  // A last item always starts a walk, so the block is busy on the next cycle.
  a_last_walks: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.last_edge) |=> busy) else $error("last item did not start a walk");

  // The slot count never runs past the adjacency store.
  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= SLOT_W'(SLOTS)) else $error("slot count beyond store");

  // The queue read pointer never overtakes the write pointer.
  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP2) |-> (rd_r <= wr_r)) else $error("queue underrun");

  // Every verdict follows a walk.
  a_verdict_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_DONE)) else $error("verdict without a walk");

endmodule
